FILE: rtl/core/wrs_pkg.sv
// shared types, codes and constants of the weighted roulette selector
`default_nettype none
package wrs_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int WEIGHT_W        = 16;
  localparam int INDEX_W         = 4;
  localparam int STATUS_W        = 2;
  localparam int TOTAL_W         = 20;
  localparam int LFSR_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int SELECT_TRIES    = 10;

  localparam logic [LFSR_W-1:0]  LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0]  LFSR_SEED = 32'h0000_0001;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hF_FFFF;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED = 2'd0,
    ST_FULL     = 2'd1,
    ST_CHOSEN   = 2'd2,
    ST_KEPT     = 2'd3
  } wrs_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MUL,
    S_SCAN,
    S_DONE
  } wrs_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/wrs_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module wrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/core/wrs_lfsr.sv
// 32-bit galois lfsr that steps on request
`default_nettype none
module wrs_lfsr (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  output logic      [wrs_pkg::LFSR_W-1:0] value
);
  import wrs_pkg::*;

  logic [LFSR_W-1:0] state_r;
  logic [LFSR_W-1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    if (step) begin
      state_nxt = (state_r >> 1) ^ (state_r[0] ? LFSR_TAPS : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LFSR_SEED;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign value = state_r;

endmodule
`default_nettype wire

FILE: rtl/core/weighted_roulette_selector.sv
// weighted roulette selector: entry table, running total and select sequencer
//
// usage: one transaction on the in_ channel gives exactly one transaction on
// the out_ channel. in_func 0 appends in_weight to the table and returns its
// index (status 0) or refuses when the table is full (status 1, index 0).
// in_func 1 draws up to ten wheel positions from the lfsr and returns the
// first entry reached that differs from in_current (status 2), or in_current
// itself (status 3) when all attempts fail.
// sequence: an append goes from idle to the done state and then into the output
// register once it is free. a select runs, per attempt, an lfsr step state, a
// multiply state and a scan state that walks the table entries until a hit or
// the end of the table, then the done state and the output register. the walk
// over the table ram, one registered read per cycle, dominates a select.
// in_ready is high only in idle, so a new item is taken only once the last one
// has moved from the done state to the output register.
// stalls: a finished result waits in the output register while out_ready is
// low; the next item may still be taken, and it then holds in its last state,
// with in_ready low, until the output register is free.
// reset (rst_n low, synchronous) empties the table, clears the total and seeds
// the lfsr with one; table contents themselves are not cleared.
`default_nettype none
module weighted_roulette_selector #(
  parameter int TABLE_DEPTH = wrs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_func,
  input  wire logic [wrs_pkg::WEIGHT_W-1:0] in_weight,
  input  wire logic [wrs_pkg::INDEX_W-1:0]  in_current,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [wrs_pkg::INDEX_W-1:0]  out_index,
  output logic      [wrs_pkg::STATUS_W-1:0] out_status
);
  import wrs_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int IW    = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = (IW > INDEX_W) ? IW : INDEX_W;
  localparam int SW    = WEIGHT_W + AW;
  localparam int CMPW  = (SW > TOTAL_W) ? SW : TOTAL_W;
  localparam int TRY_W = $clog2(SELECT_TRIES + 1);
  localparam int PW    = TOTAL_W + FRAC_W;

  wrs_state_t state_r, state_nxt;

  logic [IW-1:0]       count_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [TRY_W-1:0]    attempt_r;
  logic [IW-1:0]       idx_r;
  logic [CMPW-1:0]     sum_r;
  logic [TOTAL_W-1:0]  pos_r;
  logic [INDEX_W-1:0]  cur_r;
  logic [INDEX_W-1:0]  res_index_r;
  wrs_status_t         res_status_r;
  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_index_r;
  wrs_status_t         out_status_r;

  logic                in_fire;
  logic                full;
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [WEIGHT_W-1:0] ram_rdata;
  logic                lfsr_step;
  logic [LFSR_W-1:0]   lfsr_value;
  logic [PW-1:0]       prod;
  logic [TOTAL_W:0]    total_sum;
  logic [CMPW-1:0]     sum_add;
  logic                scan_end;
  logic                scan_hit;
  logic                is_cur;
  logic                tries_done;
  logic                out_free;

  assign in_fire    = in_valid && in_ready;
  assign full       = (count_r == IW'(TABLE_DEPTH));
  assign ram_we     = in_fire && (in_func == FUNC_APPEND) && !full;
  assign prod       = PW'(total_r) * PW'(lfsr_value[LFSR_W-1 -: FRAC_W]);
  assign total_sum  = {1'b0, total_r} + (TOTAL_W + 1)'(in_weight);
  assign sum_add    = sum_r + CMPW'(ram_rdata);
  assign scan_end   = (idx_r == count_r);
  assign scan_hit   = (sum_add >= CMPW'(pos_r));
  assign is_cur     = (CW'(idx_r) == CW'(cur_r));
  assign tries_done = (attempt_r == TRY_W'(SELECT_TRIES));
  assign out_free   = !out_valid_r || out_ready;

  wrs_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_weight),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wrs_lfsr u_lfsr (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (lfsr_step),
    .value (lfsr_value)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_func == FUNC_APPEND) ? S_DONE : S_STEP;
        end
      end
      S_STEP: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_end || scan_hit) begin
          if (!scan_end && scan_hit && !is_cur) begin
            state_nxt = S_DONE;
          end else if (tries_done) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    lfsr_step = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_STEP: lfsr_step = 1'b1;
      S_MUL:  ram_raddr = '0;
      S_SCAN: ram_raddr = AW'(idx_r + IW'(1));
      S_DONE: ;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      attempt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        count_r <= count_r + IW'(1);
        total_r <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
      end
      if (in_fire) begin
        attempt_r <= '0;
      end else if (state_r == S_STEP) begin
        attempt_r <= attempt_r + TRY_W'(1);
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cur_r <= in_current;
          if (in_func == FUNC_APPEND) begin
            res_index_r  <= full ? '0 : INDEX_W'(count_r);
            res_status_r <= full ? ST_FULL : ST_APPENDED;
          end
        end
      end
      S_STEP: ;
      S_MUL: begin
        pos_r <= prod[PW-1 -: TOTAL_W];
        idx_r <= '0;
        sum_r <= '0;
      end
      S_SCAN: begin
        sum_r <= sum_add;
        idx_r <= idx_r + IW'(1);
        if (!scan_end && scan_hit && !is_cur) begin
          res_index_r  <= INDEX_W'(idx_r);
          res_status_r <= ST_CHOSEN;
        end else begin
          res_index_r  <= cur_r;
          res_status_r <= ST_KEPT;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_index_r  <= res_index_r;
          out_status_r <= res_status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_status = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (count_r == $past(count_r) + IW'(1)))
    else $error("append did not grow the entry count");

  a_try_bound: assert property (@(posedge clk) disable iff (!rst_n)
    attempt_r <= TRY_W'(SELECT_TRIES))
    else $error("attempt counter beyond limit");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= count_r))
    else $error("scan index past entry count");

endmodule
`default_nettype wire

FILE: verif/tb_weighted_roulette_selector.sv
// testbench for the weighted roulette selector: table appends, wheel draws, stalls
`default_nettype none
module tb_weighted_roulette_selector;
  import wrs_pkg::*;

  localparam int DEPTH      = TABLE_DEPTH_DEF;
  localparam int N_RANDOM   = 1125;
  localparam int TAIL_WAIT  = 10 * (DEPTH + 3) + 20;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic                func;
    logic [WEIGHT_W-1:0] weight;
    logic [INDEX_W-1:0]  current;
    bit                  drain;
  } request_t;

  typedef struct {
    logic [INDEX_W-1:0] index;
    wrs_status_t        status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = FUNC_APPEND;
  logic [WEIGHT_W-1:0] in_weight = '0;
  logic [INDEX_W-1:0] in_current = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_W-1:0] out_index;
  logic [STATUS_W-1:0] out_status;

  request_t pending_q[$];
  outcome_t outcome_q[$];
  int n_requests = 0;
  int items_sent = 0;
  int results_seen = 0;
  int err_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int tally[4] = '{0, 0, 0, 0};
  wire quiet = (results_seen >= 200) && (results_seen < 450);

  // selector state as predicted
  logic [WEIGHT_W-1:0] wheel_weights[DEPTH];
  logic [4:0]          wheel_count = '0;
  logic [TOTAL_W-1:0]  wheel_total = '0;
  logic [LFSR_W-1:0]   wheel_lfsr = LFSR_SEED;

  weighted_roulette_selector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_weight (in_weight),
    .in_current(in_current),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (out_index),
    .out_status(out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic compute_outcome(input logic func, input logic [WEIGHT_W-1:0] weight,
                                 input logic [INDEX_W-1:0] current, output outcome_t res);
    logic [TOTAL_W:0]     grown;
    logic [FRAC_W-1:0]    frac;
    logic [35:0]          prod;
    logic [TOTAL_W-1:0]   pos;
    logic [TOTAL_W+4:0]   acc;
    logic                 out_bit;
    bit                   found;
    res.index = '0;
    found = 1'b0;
    if (func == FUNC_APPEND) begin
      if (wheel_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        wheel_weights[wheel_count] = weight;
        res.index = wheel_count[INDEX_W-1:0];
        wheel_count = wheel_count + 1'b1;
        grown = wheel_total + weight;
        wheel_total = (grown > TOTAL_MAX) ? TOTAL_MAX : grown[TOTAL_W-1:0];
        res.status = ST_APPENDED;
      end
    end else begin
      for (int t = 0; t < SELECT_TRIES && !found; t++) begin
        out_bit = wheel_lfsr[0];
        wheel_lfsr = wheel_lfsr >> 1;
        if (out_bit) begin
          wheel_lfsr = wheel_lfsr ^ LFSR_TAPS;
        end
        frac = wheel_lfsr[LFSR_W-1 -: FRAC_W];
        prod = wheel_total * frac;
        pos = prod[35:16];
        acc = '0;
        for (int i = 0; i < wheel_count && i < DEPTH; i++) begin
          acc = acc + wheel_weights[i];
          if (acc >= pos) begin
            if (i != current) begin
              res.index = i[INDEX_W-1:0];
              found = 1'b1;
            end
            break;
          end
        end
      end
      if (found) begin
        res.status = ST_CHOSEN;
      end else begin
        res.index = current;
        res.status = ST_KEPT;
      end
    end
  endtask

  task automatic queue_request(input logic func, input logic [WEIGHT_W-1:0] weight,
                               input logic [INDEX_W-1:0] current, input bit drain);
    request_t req;
    req.func = func;
    req.weight = weight;
    req.current = current;
    req.drain = drain;
    pending_q = {pending_q, req};
    n_requests++;
  endtask

  // driver
  always @(posedge clk) begin : drive_in
    request_t req;
    bit accepted;
    bit may_go;
    if (!rst_n) begin
      in_valid <= 1'b0;
      items_sent <= 0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        items_sent <= items_sent + 1;
      end
      if (!in_valid || in_ready) begin
        may_go = pending_q.size() > 0 && (quiet || $urandom_range(99) >= 6);
        if (may_go && pending_q[0].drain) begin
          may_go = !accepted && (items_sent == results_seen);
        end
        if (may_go) begin
          req = pending_q.pop_front();
          in_func <= req.func;
          in_weight <= req.weight;
          in_current <= req.current;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once the run is well along
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 700) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin : watch
    outcome_t res;
    outcome_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        compute_outcome(in_func, in_weight, in_current, res);
        outcome_q = {outcome_q, res};
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (outcome_q.size() == 0) begin
          $error("unexpected result: index %0d status %0d", out_index, out_status);
          err_count++;
        end else begin
          want = outcome_q.pop_front();
          tally[want.status]++;
          if (out_index !== want.index) begin
            $error("index: expected %0d, actual %0d", want.index, out_index);
            err_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [WEIGHT_W-1:0] fill[16];
    fill = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h0000,
             16'h0000, 16'd300, 16'd1000, 16'hFFFF, 16'd12, 16'hFFFF, 16'h00FF, 16'hFF00};
    // empty table
    queue_request(FUNC_SELECT, 16'h0000, 4'd0, 1'b0);
    queue_request(FUNC_SELECT, 16'hFFFF, 4'd15, 1'b0);
    for (int k = 0; k < 16; k++) begin
      queue_request(FUNC_APPEND, fill[k], ~4'(k), 1'b0);
      if (k == 0) begin
        queue_request(FUNC_SELECT, 16'h0000, 4'd0, 1'b0);
        queue_request(FUNC_SELECT, 16'h0000, 4'd15, 1'b0);
      end
      if (k == 7) begin
        queue_request(FUNC_SELECT, 16'h1234, 4'd3, 1'b0);
      end
    end
    // table full
    queue_request(FUNC_APPEND, 16'hFFFF, 4'd15, 1'b0);
    queue_request(FUNC_SELECT, 16'h0000, 4'd0, 1'b0);
    queue_request(FUNC_SELECT, 16'h0000, 4'd15, 1'b0);
    queue_request(FUNC_SELECT, 16'h0000, 4'd11, 1'b0);
    for (int k = 0; k < N_RANDOM; k++) begin
      queue_request(($urandom_range(99) < 15) ? FUNC_APPEND : FUNC_SELECT,
                    16'($urandom), 4'($urandom_range(15)), k == 0 || k == 800);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (!(items_sent == n_requests && results_seen == n_requests)) begin
      @(posedge clk);
    end
    repeat (TAIL_WAIT) @(posedge clk);
    if (outcome_q.size() != 0) begin
      $error("%0d expected results never arrived", outcome_q.size());
      err_count++;
    end
    $display("%0d transactions: %0d appends stored, %0d refused on a full table",
             n_requests, tally[ST_APPENDED], tally[ST_FULL]);
    $display("selects: %0d picked another entry, %0d fell back to current, %0d errors",
             tally[ST_CHOSEN], tally[ST_KEPT], err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
